### hdl/bdtl_pkg.sv
// Shared types and constants for the button debounce and trigger latch.
package bdtl_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int PIN_BITS    = 3;
    localparam int ID_BITS     = 2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef enum logic [2:0] {
        PH_INIT          = 3'd0,
        PH_PRESS_START   = 3'd1,
        PH_PRESSED       = 3'd2,
        PH_RELEASE_START = 3'd3,
        PH_RELEASED      = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN   = 2'd0,
        ST_PRESSED   = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_TRIGGERED = 2'd3
    } btn_state_t;

    typedef struct packed {
        logic sample;
        logic down;
        logic clear;
    } lane_ctrl_t;

endpackage

### hdl/bdtl_lane.sv
// One button's debounce machine and reported-state latch.
module bdtl_lane
    import bdtl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    output btn_state_t state
);

    phase_t     phase_reg, phase_next;
    btn_state_t state_reg, state_next;
    phase_t     target;
    logic       enter;

    always_comb begin
        phase_next = phase_reg;
        state_next = state_reg;
        target     = phase_reg;
        enter      = 1'b0;
        if (ctrl.clear) begin
            phase_next = PH_INIT;
            state_next = ST_UNKNOWN;
        end else if (ctrl.sample) begin
            unique case (phase_reg)
                PH_INIT: begin
                    enter  = 1'b1;
                    target = ctrl.down ? PH_PRESS_START : PH_RELEASE_START;
                end
                PH_PRESS_START: begin
                    enter  = 1'b1;
                    target = ctrl.down ? PH_PRESSED : PH_RELEASE_START;
                end
                PH_PRESSED: begin
                    enter  = !ctrl.down;
                    target = PH_RELEASE_START;
                end
                PH_RELEASE_START: begin
                    enter  = 1'b1;
                    target = ctrl.down ? PH_PRESS_START : PH_RELEASED;
                end
                PH_RELEASED: begin
                    enter  = ctrl.down;
                    target = PH_PRESS_START;
                end
                default: begin
                    enter  = 1'b0;
                    target = phase_reg;
                end
            endcase
            if (enter) begin
                phase_next = target;
                // triggered sticks until read
                if (state_reg != ST_TRIGGERED) begin
                    if (target == PH_PRESSED) begin
                        state_next = ST_PRESSED;
                    end else if (target == PH_RELEASED) begin
                        state_next = (state_reg == ST_PRESSED) ? ST_TRIGGERED : ST_RELEASED;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INIT;
            state_reg <= ST_UNKNOWN;
        end else begin
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

    a_clear_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> (state_reg == ST_UNKNOWN && phase_reg == PH_INIT))
        else $error("lane not cleared after triggered read");

endmodule

### hdl/bdtl_merge.sv
// Read selection across lanes, clear generation and buffered result channel.
module bdtl_merge
    import bdtl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   read_accept,
    input  logic [ID_BITS-1:0]     button_id,
    input  btn_state_t             lane_state [NUM_BUTTONS],
    output logic [NUM_BUTTONS-1:0] lane_clear,
    output logic                   in_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output btn_state_t             m_state
);

    btn_state_t sel_state;
    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    btn_state_t out_data_reg, out_data_next;
    btn_state_t skid_data_reg, skid_data_next;
    logic       pop;

    // Out-of-range ids match no lane and read as unknown
    always_comb begin
        sel_state  = ST_UNKNOWN;
        lane_clear = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (32'(button_id) == b) begin
                sel_state     = lane_state[b];
                lane_clear[b] = read_accept && (lane_state[b] == ST_TRIGGERED);
            end
        end
    end

    assign pop = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !pop) begin
            // hold the output, park a new transaction in the skid stage
            if (read_accept) begin
                skid_valid_next = 1'b1;
                skid_data_next  = sel_state;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = read_accept;
            out_data_next  = sel_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_state  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output empty");

    a_clear_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(lane_clear))
        else $error("more than one lane cleared");

    a_clear_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_clear != '0) |-> read_accept)
        else $error("lane cleared without a read");

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        read_accept |=> out_valid_reg)
        else $error("read accepted but no result pending");

endmodule

### hdl/button_debounce_trigger_latch_top.sv
// Read results are registered; they queue in the skid stage while m_tready is low.
// One item per cycle while s_tready is high; each sample updates all lanes at once.
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset (aresetn low, synchronous): all buttons to init phase, state unknown,
// output buffer emptied.
module button_debounce_trigger_latch_top
    import bdtl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [2:0] pin_levels, [4:3] button_id, [7:5] zero
    input  logic       s_tuser,  // [0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // [1:0] button_state, [7:2] zero
);

    logic                   accept;
    logic                   read_accept;
    logic                   sample_accept;
    logic [PIN_BITS-1:0]    pin_levels;
    logic [ID_BITS-1:0]     button_id;
    btn_state_t             lane_state [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] lane_clear;
    btn_state_t             m_state;

    assign pin_levels    = s_tdata[PIN_BITS-1:0];
    assign button_id     = s_tdata[PIN_BITS +: ID_BITS];
    assign accept        = s_tvalid && s_tready;
    assign read_accept   = accept && (s_tuser == FUNC_READ);
    assign sample_accept = accept && (s_tuser == FUNC_SAMPLE);

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        lane_ctrl_t ctrl;
        assign ctrl.sample = sample_accept;
        assign ctrl.clear  = lane_clear[b];
        // low-active pins; buttons without a pin read as released
        if (b < PIN_BITS) begin : g_pin
            assign ctrl.down = !pin_levels[b];
        end else begin : g_nopin
            assign ctrl.down = 1'b0;
        end

        bdtl_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .state   (lane_state[b])
        );
    end

    bdtl_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .read_accept (read_accept),
        .button_id   (button_id),
        .lane_state  (lane_state),
        .lane_clear  (lane_clear),
        .in_ready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_state     (m_state)
    );

    assign m_tdata = {6'd0, m_state};

endmodule

### bench/tb_button_debounce_trigger_latch_top.sv
// Self-checking bench for the button debouncer: directed table, then random streams.
module tb_button_debounce_trigger_latch_top;
    import bdtl_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic       func;
        logic [2:0] pins;
        logic [1:0] id;
        logic       fixed;
        btn_state_t state;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tuser = FUNC_SAMPLE;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    phase_t     lane_phase [NUM_BUTTONS];
    btn_state_t lane_state [NUM_BUTTONS];
    btn_state_t pending_states [$];
    int         errors = 0;
    int         stall_cycles = 0;
    bit         quiet_run = 1'b0;

    // Reset reads, a clean press and release, bounce, latch persistence, bad ids.
    stim_row_t dir_rows [0:21] = '{
        '{FUNC_READ,   3'b111, 2'd0, 1'b1, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd1, 1'b1, ST_UNKNOWN},
        '{FUNC_READ,   3'b101, 2'd2, 1'b1, ST_UNKNOWN},
        '{FUNC_READ,   3'b010, 2'd3, 1'b1, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b000, 2'd3, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b000, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b111, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b111, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b000, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b000, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd1, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b111, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b110, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b111, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_SAMPLE, 3'b111, 2'd0, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd2, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b111, 2'd3, 1'b1, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd2, 1'b0, ST_UNKNOWN},
        '{FUNC_READ,   3'b000, 2'd0, 1'b0, ST_UNKNOWN}
    };

    button_debounce_trigger_latch_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [2:0] pin_levels, [4:3] button_id, [7:5] zero
        .s_tuser  (s_tuser),   // [0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [1:0] button_state, [7:2] zero
    );

    always #5 aclk = ~aclk;

    function automatic btn_state_t latch_report(btn_state_t cur, btn_state_t nxt);
        if (cur == ST_TRIGGERED)
            return cur;
        if (cur == ST_PRESSED && nxt == ST_RELEASED)
            return ST_TRIGGERED;
        return nxt;
    endfunction

    // Advance every lane by one debounce period.
    function automatic void debounce_tick(logic [2:0] pins);
        phase_t nxt;
        logic   down;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            down = (b < PIN_BITS) ? !pins[b] : 1'b0;
            case (lane_phase[b])
                PH_INIT:          nxt = down ? PH_PRESS_START : PH_RELEASE_START;
                PH_PRESS_START:   nxt = down ? PH_PRESSED     : PH_RELEASE_START;
                PH_PRESSED:       nxt = down ? PH_PRESSED     : PH_RELEASE_START;
                PH_RELEASE_START: nxt = down ? PH_PRESS_START : PH_RELEASED;
                PH_RELEASED:      nxt = down ? PH_PRESS_START : PH_RELEASED;
                default:          nxt = lane_phase[b];
            endcase
            if (nxt == PH_PRESSED && lane_phase[b] != PH_PRESSED)
                lane_state[b] = latch_report(lane_state[b], ST_PRESSED);
            if (nxt == PH_RELEASED && lane_phase[b] != PH_RELEASED)
                lane_state[b] = latch_report(lane_state[b], ST_RELEASED);
            lane_phase[b] = nxt;
        end
    endfunction

    // Return the reported state; a triggered read clears the lane.
    function automatic btn_state_t read_lane(logic [1:0] id);
        btn_state_t st;
        st = ST_UNKNOWN;
        if (id < NUM_BUTTONS) begin
            st = lane_state[id];
            if (st == ST_TRIGGERED) begin
                lane_state[id] = ST_UNKNOWN;
                lane_phase[id] = PH_INIT;
            end
        end
        return st;
    endfunction

    task automatic send_item(logic func, logic [2:0] pins, logic [1:0] id,
                             logic fixed, btn_state_t fixed_state);
        btn_state_t st;
        while (!quiet_run && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {3'b000, id, pins};
        do @(posedge aclk); while (!s_tready);
        if (func == FUNC_READ) begin
            st = read_lane(id);
            pending_states.push_back(fixed ? fixed_state : st);
        end else begin
            debounce_tick(pins);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet_run || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        btn_state_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_states.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, m_tdata[1:0]);
                errors++;
            end else begin
                want = pending_states.pop_front();
                if (m_tdata[1:0] !== want) begin
                    $display("%0t: button_state mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata[1:0]);
                    errors++;
                end
            end
        end
    end

    // Drop the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [2:0] held_pins;
        logic [1:0] rd_id;
        int         pick;
        int         flip;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            lane_phase[b] = PH_INIT;
            lane_state[b] = ST_UNKNOWN;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].func, dir_rows[i].pins, dir_rows[i].id,
                      dir_rows[i].fixed, dir_rows[i].state);

        held_pins = 3'b111;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_run = (n >= 400 && n < 650);
            if (n == 800) begin
                // Hold off until every outstanding read has returned.
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_states.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                rd_id = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                send_item(FUNC_READ, 3'($urandom), rd_id, 1'b0, ST_UNKNOWN);
            end else begin
                // Mostly steady levels so lanes settle; occasional edges and noise.
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    send_item(FUNC_SAMPLE, 3'($urandom), 2'($urandom), 1'b0, ST_UNKNOWN);
                else begin
                    if (pick < 35) begin
                        flip = $urandom_range(0, 2);
                        held_pins[flip] = ~held_pins[flip];
                    end
                    send_item(FUNC_SAMPLE, held_pins, 2'($urandom), 1'b0, ST_UNKNOWN);
                end
            end
        end
        quiet_run = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_states.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
